// ----- rtl/nau_pkg.sv -----
// Shared types and constants for the neural activation unit.
// Used by nau_exp, nau_div and neural_activation_unit_core.
package nau_pkg;

  localparam int DATA_W = 16;
  localparam int FRAC_W = 10;

  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [30:0] EXP_C5    = 31'd1431681;
  // Horner coefficients in evaluation order: C4, C3, C2, C1, one
  localparam logic [30:0] HORNER_C [5] = '{
    31'd10327387, 31'd59597083, 31'd257941248, 31'd744261118, 31'h4000_0000
  };
  localparam logic [16:0] SELU_LAMBDA_Q16 = 17'd68859;
  localparam logic [16:0] SELU_AL_Q16     = 17'd115221;

  typedef enum logic [1:0] {
    REG_MODE     = 2'd0,
    REG_ALPHA    = 2'd1,
    REG_CLIP_MIN = 2'd2,
    REG_CLIP_MAX = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_RELU    = 3'd0,
    MODE_LEAKY   = 3'd1,
    MODE_ELU     = 3'd2,
    MODE_SELU    = 3'd3,
    MODE_SIGMOID = 3'd4,
    MODE_TANH    = 3'd5,
    MODE_HTANH   = 3'd6
  } mode_t;

  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic signed [DATA_W-1:0] x;
  } item_t;

  typedef struct packed {
    item_t       item;
    logic [46:0] prod;
  } side_t;

endpackage

// ----- rtl/neural_activation_unit_core.sv -----
// Activation unit top level: config registers, operand prep, result stage.
// One word per cycle while the output is not stalled.
// The pipeline is input reg, 7-stage exp unit, prep/multiply, 11-stage divider,
// output reg; a stalled output freezes every stage at once.
// Synchronous reset clears valid bits and loads mode 0, alpha 102, clip -1024/1024.
module neural_activation_unit_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic signed [nau_pkg::DATA_W-1:0] value_in,
  input  logic                            last_in,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic signed [nau_pkg::DATA_W-1:0] value_out,
  output logic                            last_out,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [15:0]                     cfg_data
);
  import nau_pkg::*;

  logic               adv;
  logic [2:0]         mode;
  logic [10:0]        alpha;
  logic signed [15:0] clip_min;
  logic signed [15:0] clip_max;

  assign adv        = !result_valid || result_ready;
  assign item_ready = adv;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_RELU;
      alpha    <= 11'd102;
      clip_min <= -16'sd1024;
      clip_max <= 16'sd1024;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:     mode     <= cfg_data[2:0];
        REG_ALPHA:    alpha    <= cfg_data[10:0];
        REG_CLIP_MIN: clip_min <= cfg_data;
        REG_CLIP_MAX: clip_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage
  item_t       s0_item;
  logic [16:0] s0_m;
  logic [15:0] in_mag;

  assign in_mag = value_in[15] ? 16'(-value_in) : value_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_item.valid <= 1'b0;
    end else if (adv) begin
      s0_item <= '{valid: item_valid, last: last_in, x: value_in};
      s0_m    <= (mode == MODE_TANH) ? {in_mag, 1'b0} : {1'b0, in_mag};
    end
  end

  item_t       ex_item;
  logic [30:0] ex_e;

  nau_exp u_exp (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .item_in  (s0_item),
    .m        (s0_m),
    .item_out (ex_item),
    .e        (ex_e)
  );

  // prep stage: divider operands and the one multiply
  logic [15:0] ex_mag;
  logic [30:0] ome;
  logic [31:0] den;
  logic [40:0] num;
  logic [30:0] mul_a;
  logic [16:0] mul_b;
  logic [47:0] mul_p;
  side_t       pr_side;
  logic [40:0] pr_num;
  logic [31:0] pr_den;

  assign ex_mag = ex_item.x[15] ? 16'(-ex_item.x) : ex_item.x;
  assign ome    = Q30_ONE - ex_e;
  assign den    = 32'(Q30_ONE) + 32'(ex_e);

  always_comb begin
    if (mode == MODE_TANH) begin
      num = {ome, 10'd0} + 41'(den[31:1]);
    end else begin
      num = {1'b1, 40'd0} + 41'(den[31:1]);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mode)
      MODE_LEAKY: begin
        mul_a = 31'(ex_mag);
        mul_b = 17'(alpha);
      end
      MODE_ELU: begin
        mul_a = ome;
        mul_b = 17'(alpha);
      end
      MODE_SELU: begin
        if (!ex_item.x[15]) begin
          mul_a = 31'(ex_mag);
          mul_b = SELU_LAMBDA_Q16;
        end else begin
          mul_a = ome;
          mul_b = SELU_AL_Q16;
        end
      end
      default: ;
    endcase
  end

  assign mul_p = 48'(mul_a) * 48'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_side.item.valid <= 1'b0;
    end else if (adv) begin
      pr_side.item <= ex_item;
      pr_side.prod <= mul_p[46:0];
      pr_num       <= num;
      pr_den       <= den;
    end
  end

  side_t       dv_side;
  logic [10:0] dv_q;

  nau_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .side_in  (pr_side),
    .num      (pr_num),
    .den      (pr_den),
    .side_out (dv_side),
    .q        (dv_q)
  );

  // result stage: round, sign, select, saturate
  logic signed [15:0] x;
  logic               neg;
  logic [47:0]        r10, r16, r30, r36;
  logic signed [18:0] y;
  logic signed [15:0] y_sat;

  assign x   = dv_side.item.x;
  assign neg = x[15];
  assign r10 = (48'(dv_side.prod) + (48'd1 << 9))  >> 10;
  assign r16 = (48'(dv_side.prod) + (48'd1 << 15)) >> 16;
  assign r30 = (48'(dv_side.prod) + (48'd1 << 29)) >> 30;
  assign r36 = (48'(dv_side.prod) + (48'd1 << 35)) >> 36;

  always_comb begin
    case (mode)
      MODE_RELU:    y = neg ? 19'sd0 : 19'(x);
      MODE_LEAKY:   y = neg ? -19'(r10[17:0]) : 19'(x);
      MODE_ELU:     y = neg ? -19'(r30[17:0]) : 19'(x);
      MODE_SELU:    y = neg ? -19'(r36[17:0]) : 19'(r16[17:0]);
      MODE_SIGMOID: y = neg ? (19'sd1024 - 19'(dv_q)) : 19'(dv_q);
      MODE_TANH:    y = neg ? -19'(dv_q) : 19'(dv_q);
      MODE_HTANH: begin
        if (x < clip_min) begin
          y = 19'(clip_min);
        end else if (x > clip_max) begin
          y = 19'(clip_max);
        end else begin
          y = 19'(x);
        end
      end
      default:      y = 19'(x);
    endcase
  end

  always_comb begin
    if (y > 19'sd32767) begin
      y_sat = 16'sh7fff;
    end else if (y < -19'sd32768) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= dv_side.item.valid;
      value_out    <= y_sat;
      last_out     <= dv_side.item.last;
    end
  end

  a_ready_tracks_out: assert property (@(posedge clk) disable iff (rst)
    item_ready == (!result_valid || result_ready))
    else $error("input ready does not follow output stall");

  a_relu_nonneg: assert property (@(posedge clk) disable iff (rst)
    result_valid && mode == MODE_RELU |-> !value_out[15])
    else $error("relu result negative");

  a_sigmoid_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && mode == MODE_SIGMOID |-> !value_out[15] && value_out <= 16'sd1024)
    else $error("sigmoid result out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

// ----- rtl/nau_exp.sv -----
// Pipelined exp(-m/2^10) in Q30: one multiply, five Horner steps, final shift.
// Depends on nau_pkg. Seven register stages.
module nau_exp (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  nau_pkg::item_t item_in,
  input  logic [16:0]   m,
  output nau_pkg::item_t item_out,
  output logic [30:0]   e
);
  import nau_pkg::*;

  logic [47:0] t;
  logic [29:0] f_q  [0:5];
  logic [7:0]  n_q  [0:5];
  item_t       it_q [0:5];
  logic [30:0] hp   [0:4];

  assign t = 48'(m) * 48'(LOG2E_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      it_q[0].valid <= 1'b0;
    end else if (en) begin
      it_q[0] <= item_in;
      f_q[0]  <= t[39:10];
      n_q[0]  <= t[47:40];
    end
  end

  for (genvar k = 0; k < 5; k++) begin : g_horner
    logic [30:0] p_in;
    logic [60:0] pf;
    if (k == 0) begin : g_first
      assign p_in = EXP_C5;
    end else begin : g_rest
      assign p_in = hp[k-1];
    end
    assign pf = 61'(p_in) * 61'(f_q[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        it_q[k+1].valid <= 1'b0;
      end else if (en) begin
        it_q[k+1] <= it_q[k];
        f_q[k+1]  <= f_q[k];
        n_q[k+1]  <= n_q[k];
        hp[k]     <= HORNER_C[k] - pf[60:30];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.valid <= 1'b0;
    end else if (en) begin
      item_out <= it_q[5];
      e        <= (n_q[5] >= 8'd31) ? 31'd0 : (hp[4] >> n_q[5][4:0]);
    end
  end

endmodule

// ----- rtl/nau_div.sv -----
// Restoring divider, one quotient bit per stage, eleven stages.
// Depends on nau_pkg; carries a side word alongside the quotient.
module nau_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  nau_pkg::side_t side_in,
  input  logic [40:0]    num,
  input  logic [31:0]    den,
  output nau_pkg::side_t side_out,
  output logic [10:0]    q
);
  import nau_pkg::*;

  localparam int STAGES = 11;

  logic [42:0] r_q  [0:STAGES-1];
  logic [31:0] d_q  [0:STAGES-1];
  logic [10:0] q_q  [0:STAGES-1];
  side_t       sd_q [0:STAGES-1];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [42:0] r_in;
    logic [31:0] d_in;
    logic [10:0] q_in;
    side_t       sd_in;
    logic [42:0] dd;
    logic        ge;
    if (s == 0) begin : g_first
      assign r_in  = 43'(num);
      assign d_in  = den;
      assign q_in  = '0;
      assign sd_in = side_in;
    end else begin : g_rest
      assign r_in  = r_q[s-1];
      assign d_in  = d_q[s-1];
      assign q_in  = q_q[s-1];
      assign sd_in = sd_q[s-1];
    end
    assign dd = 43'(d_in) << (STAGES - 1 - s);
    assign ge = (r_in >= dd);

    always_ff @(posedge clk) begin
      if (rst) begin
        sd_q[s].item.valid <= 1'b0;
      end else if (en) begin
        sd_q[s] <= sd_in;
        d_q[s]  <= d_in;
        r_q[s]  <= ge ? (r_in - dd) : r_in;
        q_q[s]  <= q_in | (11'(ge) << (STAGES - 1 - s));
      end
    end
  end

  assign side_out = sd_q[STAGES-1];
  assign q        = q_q[STAGES-1];

endmodule

// ----- sim/tb_top.sv -----
// Testbench for neural_activation_unit_core: a self-checking stream test.
// Depends on nau_pkg and the core RTL. An activation predictor scores every result word.

class act_scoreboard;
  logic [2:0]   mode;
  logic [10:0]  alpha;
  logic signed [15:0] clip_lo;
  logic signed [15:0] clip_hi;
  logic signed [15:0] want_value[$];
  logic         want_last[$];
  int           errors;

  function new();
    mode = nau_pkg::MODE_RELU;
    alpha = 11'd102;
    clip_lo = -16'sd1024;
    clip_hi = 16'sd1024;
    errors = 0;
  endfunction

  function void set_reg(nau_pkg::reg_idx_t idx, logic [15:0] data);
    case (idx)
      nau_pkg::REG_MODE:     mode = data[2:0];
      nau_pkg::REG_ALPHA:    alpha = data[10:0];
      nau_pkg::REG_CLIP_MIN: clip_lo = data;
      nau_pkg::REG_CLIP_MAX: clip_hi = data;
      default: ;
    endcase
  endfunction

  static function longint unsigned round_shift(longint unsigned v, int sh);
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  // exp(-m/1024) as unsigned Q30, Horner on 2^-f with truncation
  static function longint unsigned exp_q30(longint unsigned m);
    longint unsigned t, n, f, p;
    t = m * 64'd1549082005;
    n = t >> 40;
    f = (t >> 10) & ((64'd1 << 30) - 1);
    p = 64'd1431681;
    p = 64'd10327387 - ((p * f) >> 30);
    p = 64'd59597083 - ((p * f) >> 30);
    p = 64'd257941248 - ((p * f) >> 30);
    p = 64'd744261118 - ((p * f) >> 30);
    p = (64'd1 << 30) - ((p * f) >> 30);
    if (n >= 31) return 0;
    return p >> n;
  endfunction

  function logic signed [15:0] activate(logic signed [15:0] xin);
    longint x, y;
    longint unsigned mag, e, p, one;
    one = 64'd1 << 30;
    x = xin;
    mag = (x < 0) ? -x : x;
    case (mode)
      nau_pkg::MODE_RELU:  y = (x > 0) ? x : 0;
      nau_pkg::MODE_LEAKY: y = (x >= 0) ? x : -longint'(round_shift(mag * alpha, 10));
      nau_pkg::MODE_ELU: begin
        if (x >= 0) y = x;
        else y = -longint'(round_shift(alpha * (one - exp_q30(mag)), 30));
      end
      nau_pkg::MODE_SELU: begin
        if (x >= 0) y = round_shift(mag * 64'd68859, 16);
        else y = -longint'(round_shift((one - exp_q30(mag)) * 64'd115221, 36));
      end
      nau_pkg::MODE_SIGMOID: begin
        e = exp_q30(mag);
        p = ((one << 10) + ((one + e) >> 1)) / (one + e);
        y = (x >= 0) ? longint'(p) : 1024 - longint'(p);
      end
      nau_pkg::MODE_TANH: begin
        e = exp_q30(mag << 1);
        p = (((one - e) << 10) + ((one + e) >> 1)) / (one + e);
        y = (x >= 0) ? longint'(p) : -longint'(p);
      end
      nau_pkg::MODE_HTANH: y = (x < clip_lo) ? clip_lo : ((x > clip_hi) ? clip_hi : x);
      default: y = x;
    endcase
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return y[15:0];
  endfunction

  function void note_input(logic signed [15:0] x, logic last);
    want_value.push_back(activate(x));
    want_last.push_back(last);
  endfunction

  task report(string what);
    errors++;
    $display("[%0t] error: %s", $time, what);
  endtask

  task check_result(logic signed [15:0] v, logic last);
    logic signed [15:0] wv;
    logic wl;
    if (want_value.size() == 0) begin
      report($sformatf("unexpected result word value=%0d", v));
      return;
    end
    wv = want_value.pop_front();
    wl = want_last.pop_front();
    if (v !== wv) report($sformatf("value_out %0d, want %0d (mode %0d)", v, wv, mode));
    if (last !== wl) report($sformatf("last_out %b, want %b", last, wl));
  endtask

  function int pending();
    return want_value.size();
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nau_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  logic signed [15:0] value_in = '0;
  logic last_in = 1'b0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic signed [15:0] value_out;
  logic last_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  reg_idx_t cfg_index = REG_MODE;
  logic [15:0] cfg_data = '0;
  logic quiet = 1'b0;

  act_scoreboard sb = new();

  always #4 clk = ~clk;

  neural_activation_unit_core dut (.*);

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) sb.note_input(value_in, last_in);
      if (result_valid && result_ready) sb.check_result(value_out, last_out);
    end
  end

  // random output stall, none while quiet
  always @(negedge clk) begin
    result_ready <= quiet || ($urandom_range(99) >= 20);
  end

  task send_word(logic signed [15:0] x, logic last);
    if (!quiet && $urandom_range(99) < 20) begin
      @(negedge clk);
      item_valid = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    item_valid = 1'b1;
    value_in = x;
    last_in = last;
    do @(posedge clk); while (!item_ready);
  endtask

  task write_reg(reg_idx_t idx, logic [15:0] data);
    @(negedge clk);
    item_valid = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // drain the pipe before touching the registers
  task drain();
    @(negedge clk);
    item_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function logic signed [15:0] rand_value();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return $signed(16'($urandom_range(16384))) - 16'sd8192;
      2: return $signed(16'($urandom_range(2048))) - 16'sd1024;
      default: return $signed(16'($urandom_range(64))) - 16'sd32;
    endcase
  endfunction

  logic signed [15:0] edge_vals[12] = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, 16'sh8000,
    16'sd1024, -16'sd1024, 16'sd3000, -16'sd3000, -16'sd12000, 16'sd12000, -16'sd2};
  logic [15:0] alpha_pick[4] = '{16'd0, 16'd1024, 16'd2047, 16'd102};

  initial begin
    int m;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset settings, then every mode over the field extremes
    for (int i = 0; i < 12; i++) send_word(edge_vals[i], i[0]);
    drain();
    write_reg(REG_CLIP_MIN, 16'h8000);
    write_reg(REG_CLIP_MAX, 16'h7fff);
    for (m = 0; m < 8; m++) begin
      write_reg(REG_MODE, m[15:0]);
      write_reg(REG_ALPHA, alpha_pick[m % 4]);
      for (int i = 0; i < 6; i++) send_word(edge_vals[(i + m) % 12], i[0]);
      drain();
    end
    // crossed clip bounds
    write_reg(REG_MODE, 16'(MODE_HTANH));
    write_reg(REG_CLIP_MIN, 16'd500);
    write_reg(REG_CLIP_MAX, 16'hfe00);
    for (int i = 0; i < 6; i++) send_word(edge_vals[i + 3], 1'b1);
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      quiet = (ph == 6 || ph == 7);
      write_reg(REG_MODE, 16'($urandom_range(7)));
      write_reg(REG_ALPHA, ($urandom_range(3) == 0) ? alpha_pick[$urandom_range(3)]
                                                    : 16'($urandom_range(2047)));
      write_reg(REG_CLIP_MIN, ($urandom_range(3) == 0) ? 16'h8000 : rand_value());
      write_reg(REG_CLIP_MAX, ($urandom_range(3) == 0) ? 16'h7fff : rand_value());
      for (int i = 0; i < 115; i++) send_word(rand_value(), 1'($urandom_range(1)));
      drain();
    end
    quiet = 1'b0;

    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ----- neural_activation_unit_core.f -----
rtl/nau_pkg.sv
rtl/nau_exp.sv
rtl/nau_div.sv
rtl/neural_activation_unit_core.sv
sim/tb_top.sv
